FILE: sv/qrs_pkg.sv
package qrs_pkg;

  localparam int DISC_W = 67;
  localparam int ROOT_W = 35;
  localparam int DEN_W  = 33;
  localparam int MAG_W  = 35;

  typedef logic [1:0] status_t;

  localparam status_t ST_REAL    = 2'd0;
  localparam status_t ST_LINEAR  = 2'd1;
  localparam status_t ST_COMPLEX = 2'd2;
  localparam status_t ST_NONE    = 2'd3;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [32:0] b;
    logic signed [33:0] e;
    status_t            kind;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [DISC_W-1:0]  disc;
  } front_t;

  typedef struct packed {
    logic    neg_p;
    logic    neg_m;
    status_t kind;
  } div_side_t;

endpackage

FILE: sv/qrs_front.sv
module qrs_front
  import qrs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] coef_quad,
  input  logic signed [31:0] coef_lin,
  input  logic signed [31:0] const_left,
  input  logic signed [31:0] const_right,
  input  logic               lin_minus,
  input  logic               const_minus,
  output front_t             front
);

  logic signed [31:0] a1;
  logic signed [32:0] b1;
  logic signed [33:0] e1;
  logic signed [32:0] b1_next;
  logic signed [32:0] c1_next;
  logic signed [33:0] e1_next;

  side_t              side2;
  logic [63:0]        bb2;
  logic [64:0]        p2;
  logic               ae_neg2;
  side_t              side2_next;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [32:0]        mag_e;
  logic [32:0]        neg_a;
  logic [32:0]        neg_b;
  logic [33:0]        neg_e;

  logic [67:0]        diff;
  front_t             front_next;

  always_comb begin
    b1_next = lin_minus ? -{coef_lin[31], coef_lin} : {coef_lin[31], coef_lin};
    c1_next = const_minus ? -{const_left[31], const_left} : {const_left[31], const_left};
    e1_next = {c1_next[32], c1_next} - {{2{const_right[31]}}, const_right};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= coef_quad;
      b1 <= b1_next;
      e1 <= e1_next;
    end
  end

  always_comb begin
    neg_a = -{a1[31], a1};
    neg_b = -b1;
    neg_e = -e1;
    mag_a = a1[31] ? neg_a[31:0] : a1;
    mag_b = b1[32] ? neg_b[31:0] : b1[31:0];
    mag_e = e1[33] ? neg_e[32:0] : e1[32:0];
    side2_next.a = a1;
    side2_next.b = b1;
    side2_next.e = e1;
    if (a1 == 32'sd0) begin
      side2_next.kind = (b1 == 33'sd0) ? ST_NONE : ST_LINEAR;
    end else begin
      side2_next.kind = ST_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2   <= side2_next;
      bb2     <= {32'd0, mag_b} * {32'd0, mag_b};
      p2      <= {33'd0, mag_a} * {32'd0, mag_e};
      ae_neg2 <= (e1 != 34'sd0) && (a1[31] != e1[33]);
    end
  end

  always_comb begin
    diff = {4'd0, bb2} - {1'b0, p2, 2'b00};
    front_next.side = side2;
    if (ae_neg2) begin
      front_next.disc = {3'd0, bb2} + {p2, 2'b00};
    end else if (diff[67]) begin
      front_next.disc = '0;
      if (side2.kind == ST_REAL) begin
        front_next.side.kind = ST_COMPLEX;
      end
    end else begin
      front_next.disc = diff[66:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

FILE: sv/qrs_sqrt.sv
module qrs_sqrt
  import qrs_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DISC_W-1:0] disc,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_i  [ROOT_W];
  logic [REM_W-1:0]  rem_i  [ROOT_W];
  logic [ROOT_W-1:0] root_i [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0] shl;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;

    if (k == 0) begin : g_first
      assign rad_i[k]  = {{(RAD_W-DISC_W){1'b0}}, disc};
      assign rem_i[k]  = '0;
      assign root_i[k] = '0;
    end else begin : g_next
      assign rad_i[k]  = rad_r[k-1];
      assign rem_i[k]  = rem_r[k-1];
      assign root_i[k] = root_r[k-1];
    end

    always_comb begin
      shl   = {rem_i[k], rad_i[k][RAD_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, root_i[k], 2'b01};
      diff  = shl - trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= {rad_i[k][RAD_W-3:0], 2'b00};
        if (!diff[REM_W+1]) begin
          rem_r[k]  <= diff[REM_W-1:0];
          root_r[k] <= {root_i[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= shl[REM_W-1:0];
          root_r[k] <= {root_i[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

FILE: sv/qrs_div.sv
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NUM_W = 51
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0] num_r [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] quo_r [NUM_W];
  logic [NUM_W-1:0] num_i [NUM_W];
  logic [DEN_W-1:0] den_i [NUM_W];
  logic [DEN_W-1:0] rem_i [NUM_W];
  logic [NUM_W-1:0] quo_i [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W+1:0] shl;
    logic [DEN_W+1:0] diff;

    if (k == 0) begin : g_first
      assign num_i[k] = num;
      assign den_i[k] = den;
      assign rem_i[k] = '0;
      assign quo_i[k] = '0;
    end else begin : g_next
      assign num_i[k] = num_r[k-1];
      assign den_i[k] = den_r[k-1];
      assign rem_i[k] = rem_r[k-1];
      assign quo_i[k] = quo_r[k-1];
    end

    always_comb begin
      shl  = {1'b0, rem_i[k], num_i[k][NUM_W-1]};
      diff = shl - {2'b00, den_i[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= {num_i[k][NUM_W-2:0], 1'b0};
        den_r[k] <= den_i[k];
        if (!diff[DEN_W+1]) begin
          rem_r[k] <= diff[DEN_W-1:0];
          quo_r[k] <= {quo_i[k][NUM_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= shl[DEN_W-1:0];
          quo_r[k] <= {quo_i[k][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[NUM_W-1];

endmodule

FILE: sv/quadratic_root_solver.sv
// Solves a*x^2 + b*x + c = d in signed fixed point with FRAC_BITS fraction bits and returns
// both real roots, the linear root when a is zero, or -1.0 with a status code for complex
// roots and for an equation without a solution. The block takes one transaction in every
// cycle while the output side does not stall. Each result passes through three front
// stages that form the discriminant, a 35-stage pipelined square root, then one set-up
// stage, two restoring dividers of one quotient bit per stage working side by side, and
// the output register. A stall on the output side holds the whole pipeline without
// losing or repeating a transaction.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // coef_quad, coef_lin, const_left, const_right
  input  logic [1:0]   s_tuser,  // lin_minus, const_minus
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // root_plus, root_minus
  output logic [2:0]   m_tuser   // status, saturated
);

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int LAT   = 3 + ROOT_W + 1 + NUM_W + 1;
  localparam logic [31:0] ERR = ~((32'd1 << FRAC_BITS) - 32'd1);

  logic              en;
  logic [LAT-1:0]    valid;
  front_t            front;
  logic [ROOT_W-1:0] root;
  side_t             side1 [ROOT_W];
  div_side_t         side2 [NUM_W];
  logic [NUM_W-1:0]  num_p;
  logic [NUM_W-1:0]  num_m;
  logic [DEN_W-1:0]  den;
  div_side_t         prep;
  logic [NUM_W-1:0]  quo_p;
  logic [NUM_W-1:0]  quo_m;

  logic signed [35:0] rt_s;
  logic signed [35:0] b_s;
  logic signed [35:0] np_s;
  logic signed [35:0] nm_s;
  logic signed [33:0] den_s;
  logic [35:0]        np_neg;
  logic [35:0]        nm_neg;
  logic [33:0]        den_neg;
  logic [MAG_W-1:0]   mag_p;
  logic [MAG_W-1:0]   mag_m;
  div_side_t          prep_next;

  logic [32:0] clip_p;
  logic [32:0] clip_m;
  logic [63:0] data_next;
  logic [2:0]  user_next;

  function automatic logic [32:0] clip(input logic [NUM_W-1:0] q, input logic neg);
    logic        big_neg;
    logic        big_pos;
    logic [31:0] inv;
    big_neg = (|q[NUM_W-1:32]) || (q[31] && (|q[30:0]));
    big_pos = |q[NUM_W-1:31];
    inv     = ~q[31:0] + 32'd1;
    if (neg && (q != '0)) begin
      clip = big_neg ? {1'b1, 32'h8000_0000} : {1'b0, inv};
    end else begin
      clip = big_pos ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
    end
  endfunction

  assign en       = !valid[LAT-1] || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[LAT-2:0], s_tvalid};
    end
  end

  qrs_front u_front (
    .clk         (clk),
    .en          (en),
    .coef_quad   (s_tdata[31:0]),
    .coef_lin    (s_tdata[63:32]),
    .const_left  (s_tdata[95:64]),
    .const_right (s_tdata[127:96]),
    .lin_minus   (s_tuser[0]),
    .const_minus (s_tuser[1]),
    .front       (front)
  );

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .disc (front.disc),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side1[0] <= front.side;
      for (int i = 1; i < ROOT_W; i++) begin
        side1[i] <= side1[i-1];
      end
    end
  end

  always_comb begin
    rt_s = {1'b0, root};
    b_s  = {{3{side1[ROOT_W-1].b[32]}}, side1[ROOT_W-1].b};
    nm_s = -(b_s + rt_s);
    if (side1[ROOT_W-1].kind == ST_LINEAR) begin
      np_s  = -{{2{side1[ROOT_W-1].e[33]}}, side1[ROOT_W-1].e};
      den_s = {side1[ROOT_W-1].b[32], side1[ROOT_W-1].b};
    end else begin
      np_s  = rt_s - b_s;
      den_s = {side1[ROOT_W-1].a[31], side1[ROOT_W-1].a, 1'b0};
    end
    np_neg  = -np_s;
    nm_neg  = -nm_s;
    den_neg = -den_s;
    mag_p   = np_s[35] ? np_neg[MAG_W-1:0] : np_s[MAG_W-1:0];
    mag_m   = nm_s[35] ? nm_neg[MAG_W-1:0] : nm_s[MAG_W-1:0];
    prep_next.neg_p = np_s[35] != den_s[33];
    prep_next.neg_m = nm_s[35] != den_s[33];
    prep_next.kind  = side1[ROOT_W-1].kind;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_p <= {mag_p, {FRAC_BITS{1'b0}}};
      num_m <= {mag_m, {FRAC_BITS{1'b0}}};
      den   <= den_s[33] ? den_neg[DEN_W-1:0] : den_s[DEN_W-1:0];
      prep  <= prep_next;
    end
  end

  qrs_div #(.NUM_W(NUM_W)) u_div_p (
    .clk (clk),
    .en  (en),
    .num (num_p),
    .den (den),
    .quo (quo_p)
  );

  qrs_div #(.NUM_W(NUM_W)) u_div_m (
    .clk (clk),
    .en  (en),
    .num (num_m),
    .den (den),
    .quo (quo_m)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side2[0] <= prep;
      for (int i = 1; i < NUM_W; i++) begin
        side2[i] <= side2[i-1];
      end
    end
  end

  always_comb begin
    clip_p = clip(quo_p, side2[NUM_W-1].neg_p);
    clip_m = clip(quo_m, side2[NUM_W-1].neg_m);
    case (side2[NUM_W-1].kind)
      ST_REAL: begin
        data_next = {clip_m[31:0], clip_p[31:0]};
        user_next = {clip_p[32] | clip_m[32], ST_REAL};
      end
      ST_LINEAR: begin
        data_next = {32'd0, clip_p[31:0]};
        user_next = {clip_p[32], ST_LINEAR};
      end
      ST_COMPLEX: begin
        data_next = {ERR, ERR};
        user_next = {1'b0, ST_COMPLEX};
      end
      default: begin
        data_next = {ERR, ERR};
        user_next = {1'b0, ST_NONE};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= data_next;
      m_tuser <= user_next;
    end
  end

endmodule

FILE: tb/sv/quadratic_root_solver_tb.sv
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam int N_RANDOM = 540;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic               b_neg;
    logic               c_neg;
  } equation_t;

  typedef struct packed {
    logic [31:0] rp;
    logic [31:0] rm;
    status_t     st;
    logic        sat;
  } roots_t;

  typedef struct packed {
    equation_t q;
    logic      typed;
    roots_t    r;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;

  roots_t pending_roots[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     feed_done = 1'b0;

  quadratic_root_solver uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [32:0] fixed_div(input logic signed [71:0] num,
                                            input logic signed [71:0] den);
    logic [71:0] mn, md, qq;
    logic        neg;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    qq = (mn << 16) / md;
    neg = ((num < 0) != (den < 0)) && (qq != 0);
    if (neg) begin
      if (qq > 72'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-qq)};
    end
    if (qq > 72'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, qq[31:0]};
  endfunction

  function automatic roots_t predict(input equation_t q);
    logic signed [71:0] aw, bw, cw, ew, disc, den;
    logic [71:0]        rt, t;
    logic [32:0]        p, m;
    roots_t             r;
    aw = q.a;
    bw = q.b;
    cw = q.c;
    if (q.b_neg) bw = -bw;
    if (q.c_neg) cw = -cw;
    ew = cw - 72'(q.d);
    r = '{rp: NEG_ONE, rm: NEG_ONE, st: ST_NONE, sat: 1'b0};
    if (aw == 0) begin
      if (bw != 0) begin
        p = fixed_div(-ew, bw);
        r = '{rp: p[31:0], rm: 32'h0, st: ST_LINEAR, sat: p[32]};
      end
    end else begin
      disc = bw * bw - 4 * aw * ew;
      if (disc < 0) begin
        r.st = ST_COMPLEX;
      end else begin
        rt = 0;
        for (int i = 35; i >= 0; i--) begin
          t = rt | (72'd1 << i);
          if (t * t <= disc) rt = t;
        end
        den = 2 * aw;
        p = fixed_div($signed(rt) - bw, den);
        m = fixed_div(-(bw + $signed(rt)), den);
        r = '{rp: p[31:0], rm: m[31:0], st: ST_REAL, sat: p[32] | m[32]};
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] small_q(input int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic offer(input equation_t q, input logic typed, input roots_t r, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {q.d, q.c, q.b, q.a};
    s_tuser  <= {q.c_neg, q.b_neg};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_roots.push_back(typed ? r : predict(q));
    @(negedge clk);
  endtask

  row_t directed[] = '{
    '{'{32'sh0, 32'sh0, 32'sh5_0000, 32'sh3_0000, 1'b0, 1'b0}, 1'b1,
      '{NEG_ONE, NEG_ONE, ST_NONE, 1'b0}},
    '{'{32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b1}, 1'b1,
      '{NEG_ONE, NEG_ONE, ST_NONE, 1'b0}},
    '{'{ONE, 32'sh0, ONE, 32'sh0, 1'b0, 1'b0}, 1'b1,
      '{NEG_ONE, NEG_ONE, ST_COMPLEX, 1'b0}},
    '{'{ONE, 32'sh0, ONE, 32'sh0, 1'b0, 1'b1}, 1'b1,
      '{ONE, NEG_ONE, ST_REAL, 1'b0}},
    '{'{32'sh0, ONE, 32'sh2_0000, 32'sh0, 1'b0, 1'b0}, 1'b1,
      '{32'hFFFE_0000, 32'h0, ST_LINEAR, 1'b0}},
    '{'{32'sh0, ONE, 32'sh2_0000, 32'sh0, 1'b1, 1'b0}, 1'b1,
      '{32'h0002_0000, 32'h0, ST_LINEAR, 1'b0}},
    '{'{32'sh0, 32'sh3_0000, 32'sh7_0000, 32'sh7_0000, 1'b0, 1'b0}, 1'b1,
      '{32'h0, 32'h0, ST_LINEAR, 1'b0}},
    '{'{32'sh0, 32'sh1, 32'sh7FFF_FFFF, 32'sh0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh0, 32'sh1, 32'sh7FFF_FFFF, 32'sh0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{32'shFFFF_0000, 32'sh2_0000, 32'sh3_0000, 32'shFFFF_0000, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh2_0000, 32'shFFFB_0000, 32'sh2_0000, 32'sh0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh1, 32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'sh1, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 1'b1, 1'b0}, 1'b0, '0}
  };

  initial begin
    equation_t q;
    int        kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i])
      offer(directed[i].q, directed[i].typed, directed[i].r, $urandom_range(0, 3));
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      q.a = $urandom;
      q.b = $urandom;
      q.c = $urandom;
      q.d = $urandom;
      q.b_neg = 1'($urandom_range(0, 1));
      q.c_neg = 1'($urandom_range(0, 1));
      if (kind >= 3) begin
        q.a = small_q(8 << 16);
        q.b = small_q(40 << 16);
        q.c = small_q(20 << 16);
        q.d = small_q(20 << 16);
      end
      if (kind == 9) q.a = 32'sh0;
      if (kind == 8 && $urandom_range(0, 1)) q.b = 32'sh0;
      offer(q, 1'b0, '0, ((i / 60) % 3 == 0) ? 0 : $urandom_range(0, 15));
    end
    s_tvalid <= 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    int gap;
    int n;
    n = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (n == 40) gap = 400;
      else if ((n / 50) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{rp: m_tdata[31:0], rm: m_tdata[63:32], st: m_tuser[1:0], sat: m_tuser[2]};
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        if (got.rp !== want.rp) begin
          $display("%0t: root_plus expected %h actual %h", $time, want.rp, got.rp);
          errors++;
        end
        if (got.rm !== want.rm) begin
          $display("%0t: root_minus expected %h actual %h", $time, want.rm, got.rm);
          errors++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    wait (feed_done);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
